// File: rtl/core/signed_int32_divider_saturating_unit_assert.svh
// ----------------------------------------------------------------------------
// signed_int32_divider_saturating_unit_assert.svh
// Assertion macros for the signed divider; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT32_DIVIDER_SATURATING_UNIT_ASSERT_SVH
`define SIGNED_INT32_DIVIDER_SATURATING_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off while in reset
`define SID_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sid assertion failed");

// next-cycle implication
`define SID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sid assertion failed");

`else

`define SID_ASSERT_IMPLY(label, ante, cons)
`define SID_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Widths, beat types and pipeline word for the signed divider.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int DW = 32;

    localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic signed [DW-1:0] numerator;
        logic signed [DW-1:0] denominator;
    } operands_t;

    typedef struct packed {
        logic signed [DW-1:0] quotient_out;
        logic                 zero_divisor;
    } result_t;

    // one pipeline word: dq holds the unshifted dividend bits on top and
    // the quotient bits shifted in at the bottom
    typedef struct packed {
        logic          valid;
        logic          zero;
        logic          neg;
        logic [DW-1:0] rem;
        logic [DW-1:0] dq;
        logic [DW-1:0] dsr;
    } work_t;

endpackage

// File: rtl/core/sid_prep.sv
// ----------------------------------------------------------------------------
// sid_prep
// Operand register: magnitudes, result sign and zero-divisor flag.
// ----------------------------------------------------------------------------
module sid_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sid_pkg::operands_t operands,
    output sid_pkg::work_t     work
);
    import sid_pkg::*;

    logic          valid_reg;
    work_t         data_reg;
    work_t         data_next;
    logic          n_neg;
    logic          d_neg;

    always_comb
    begin
        n_neg           = operands.numerator[DW-1];
        d_neg           = operands.denominator[DW-1];
        data_next       = '0;
        data_next.zero  = (operands.denominator == '0);
        data_next.neg   = n_neg ^ d_neg;
        data_next.rem   = '0;
        // the most negative value negates to itself, read as 2^(DW-1) unsigned
        data_next.dq    = n_neg ? (~operands.numerator + 1'b1) : operands.numerator;
        data_next.dsr   = d_neg ? (~operands.denominator + 1'b1) : operands.denominator;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        work       = data_reg;
        work.valid = valid_reg;
    end

endmodule

// File: rtl/core/sid_step.sv
// ----------------------------------------------------------------------------
// sid_step
// One registered restoring-division step: shift in a dividend bit, trial
// subtract, keep or restore.
// ----------------------------------------------------------------------------
`include "signed_int32_divider_saturating_unit_assert.svh"

module sid_step (
    input  logic           clk,
    input  logic           rst_n,
    input  sid_pkg::work_t work_in,
    output sid_pkg::work_t work_out
);
    import sid_pkg::*;

    logic          valid_reg;
    work_t         data_reg;
    work_t         data_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        trial     = {work_in.rem, work_in.dq[DW-1]};
        diff      = trial - {1'b0, work_in.dsr};
        data_next = work_in;
        if (!diff[DW])
        begin
            data_next.rem = diff[DW-1:0];
            data_next.dq  = {work_in.dq[DW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[DW-1:0];
            data_next.dq  = {work_in.dq[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= work_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        work_out       = data_reg;
        work_out.valid = valid_reg;
    end

    `SID_ASSERT_NEXT(a_step_valid_moves, work_in.valid, work_out.valid)
    `SID_ASSERT_IMPLY(a_step_rem_below_dsr, work_out.valid && (work_out.dsr != '0),
                      work_out.rem < work_out.dsr)

endmodule

// File: rtl/core/sid_post.sv
// ----------------------------------------------------------------------------
// sid_post
// Output register: applies sign, saturation and the zero-divisor case.
// ----------------------------------------------------------------------------
module sid_post (
    input  logic             clk,
    input  logic             rst_n,
    input  sid_pkg::work_t   work,
    output logic             done,
    output sid_pkg::result_t result
);
    import sid_pkg::*;

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        result_next.zero_divisor = work.zero;
        if (work.zero)
        begin
            result_next.quotient_out = '0;
        end
        else if (work.neg)
        begin
            result_next.quotient_out = ~work.dq + 1'b1;
        end
        else if (work.dq[DW-1])
        begin
            // MIN / -1 overflows
            result_next.quotient_out = QMAX;
        end
        else
        begin
            result_next.quotient_out = work.dq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= work.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/signed_int32_divider_saturating_unit.sv
// ----------------------------------------------------------------------------
// signed_int32_divider_saturating_unit
// Pipelined signed 32-bit divider, quotient truncated toward zero and
// saturated on MIN / -1; a zero divisor is flagged and gives 0.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------
//  operands  | start, busy      | numerator, denominator (beat on start && !busy)
//  result    | done (1 cycle)   | quotient_out, zero_divisor
//
//  One beat accepted per cycle; busy is always low.
//  Pipeline: operand register, one stage per quotient bit, output register.
//  The divide chain accepts a new beat while earlier ones are in flight.
//  Reset clears the valid bits only; no clearing pass.
//  The result is not held: done marks it for exactly one cycle.
// ----------------------------------------------------------------------------
`include "signed_int32_divider_saturating_unit_assert.svh"

module signed_int32_divider_saturating_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sid_pkg::operands_t operands,
    output logic               done,
    output sid_pkg::result_t   result
);
    import sid_pkg::*;

    work_t stage_w [DW+1];

    assign busy = 1'b0;

    sid_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (start && !busy),
        .operands (operands),
        .work     (stage_w[0])
    );

    for (genvar i = 0; i < DW; i++)
    begin : g_step
        sid_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .work_in  (stage_w[i]),
            .work_out (stage_w[i+1])
        );
    end

    sid_post u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .work   (stage_w[DW]),
        .done   (done),
        .result (result)
    );

    `SID_ASSERT_IMPLY(a_zero_gives_zero, done && result.zero_divisor,
                      result.quotient_out == '0)

endmodule

// File: bench/signed_int32_divider_saturating_unit_tb.sv
// ----------------------------------------------------------------------------
// signed_int32_divider_saturating_unit_tb
// Self-checking bench for the pipelined signed divider. Operand beats are
// sent in random bursts and each quotient is checked against a bit-level
// restoring-division predictor, covering saturation, zero divisors and the
// most negative operands.
// ----------------------------------------------------------------------------
module signed_int32_divider_saturating_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sid_pkg::*;

    localparam logic [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};
    localparam int RANDOM_BEATS = 1900;
    localparam int SETTLE_CYCLES = DW + 10;
    localparam longint CYCLE_LIMIT = 200000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    operands_t operands;
    logic      done;
    result_t   result;

    result_t   pending_quotients[$];
    int        error_count;
    longint    cycle_count;

    signed_int32_divider_saturating_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // truncating signed divide on magnitudes, MIN taken as 2^(DW-1)
    function automatic result_t divide_saturating(input operands_t op);
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic [DW:0]   partial;
        logic [DW-1:0] quo_mag;
        logic          num_neg;
        logic          den_neg;
        result_t       res;
        begin
            num_neg = op.numerator[DW-1];
            den_neg = op.denominator[DW-1];
            num_mag = num_neg ? -op.numerator : op.numerator;
            den_mag = den_neg ? -op.denominator : op.denominator;
            res = '0;
            if (op.denominator == '0)
            begin
                res.zero_divisor = 1'b1;
                return res;
            end
            partial = '0;
            quo_mag = '0;
            for (int i = DW - 1; i >= 0; i--)
            begin
                partial = {partial[DW-1:0], num_mag[i]};
                quo_mag = {quo_mag[DW-2:0], 1'b0};
                if (partial >= {1'b0, den_mag})
                begin
                    partial = partial - {1'b0, den_mag};
                    quo_mag[0] = 1'b1;
                end
            end
            if (num_neg != den_neg)
                res.quotient_out = -quo_mag;
            else if (quo_mag[DW-1])
                res.quotient_out = QMAX;
            else
                res.quotient_out = quo_mag;
            return res;
        end
    endfunction

    // result checking and expectation capture, both on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_quotients.size() == 0)
                begin
                    $display("%0t: unexpected result beat quotient=%0d zero_divisor=%0b",
                             $time, result.quotient_out, result.zero_divisor);
                    error_count++;
                end
                else
                begin
                    result_t want;
                    want = pending_quotients.pop_front();
                    if (result.quotient_out !== want.quotient_out)
                    begin
                        $display("%0t: quotient_out mismatch expected=%0d actual=%0d",
                                 $time, want.quotient_out, result.quotient_out);
                        error_count++;
                    end
                    if (result.zero_divisor !== want.zero_divisor)
                    begin
                        $display("%0t: zero_divisor mismatch expected=%0b actual=%0b",
                                 $time, want.zero_divisor, result.zero_divisor);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                pending_quotients.push_back(divide_saturating(operands));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one beat; start stays high so back-to-back beats need no extra edge
    task automatic send_operands(input logic [DW-1:0] num, input logic [DW-1:0] den);
        begin
            @(negedge clk);
            start <= 1'b1;
            operands <= '{numerator: num, denominator: den};
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        begin
            repeat (n)
            begin
                @(negedge clk);
                start <= 1'b0;
                operands <= {$urandom, $urandom};
            end
        end
    endtask

    task automatic drain_results();
        begin
            idle_cycles(1);
            while (pending_quotients.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [DW-1:0] random_dividend();
        begin
            case ($urandom_range(0, 11))
                0:       return MOST_NEG;
                1:       return QMAX;
                2:       return DW'($urandom_range(0, 64)) - DW'(32);
                3:       return $urandom >> $urandom_range(0, DW - 1);
                4:       return -($urandom >> $urandom_range(0, DW - 1));
                default: return $urandom;
            endcase
        end
    endfunction

    function automatic logic [DW-1:0] random_divisor();
        begin
            case ($urandom_range(0, 15))
                0:       return '0;
                1:       return MINUS_ONE;
                2:       return MOST_NEG;
                3:       return DW'(1);
                4:       return QMAX;
                5, 6:    return DW'($urandom_range(0, 32)) - DW'(16);
                7, 8:    return $urandom >> $urandom_range(0, DW - 1);
                9, 10:   return -($urandom >> $urandom_range(0, DW - 1));
                default: return $urandom;
            endcase
        end
    endfunction

    task automatic test_extreme_operands();
        begin
            send_operands(QMAX, QMAX);
            send_operands(QMAX, MINUS_ONE);
            send_operands(QMAX, MOST_NEG);
            send_operands(QMAX, DW'(1));
            send_operands('0, MOST_NEG);
            send_operands('0, MINUS_ONE);
            send_operands(DW'(7), -DW'(2));
            send_operands(-DW'(7), DW'(2));
            send_operands(-DW'(7), -DW'(2));
            send_operands(DW'(1), MOST_NEG);
            send_operands(MINUS_ONE, MOST_NEG);
            send_operands(MINUS_ONE, MINUS_ONE);
            send_operands(DW'(1), DW'(1));
            send_operands(32'h5555_5555, 32'hAAAA_AAAA);
            drain_results();
        end
    endtask

    task automatic test_zero_divisor();
        begin
            send_operands(DW'(5), '0);
            send_operands(MOST_NEG, '0);
            send_operands('0, '0);
            send_operands(MINUS_ONE, '0);
            send_operands(QMAX, '0);
            drain_results();
        end
    endtask

    // saturation and true 2^(DW-1) magnitude of the most negative value
    task automatic test_most_negative();
        begin
            send_operands(MOST_NEG, MINUS_ONE);
            send_operands(MOST_NEG, MOST_NEG);
            send_operands(MOST_NEG, DW'(2));
            send_operands(MOST_NEG, DW'(1));
            send_operands(MOST_NEG, DW'(3));
            send_operands(MOST_NEG, QMAX);
            drain_results();
        end
    endtask

    task automatic test_random_stream();
        int sent;
        int burst;
        begin
            sent = 0;
            while (sent < RANDOM_BEATS)
            begin
                if ($urandom_range(0, 9) == 0)
                    burst = $urandom_range(60, 150);
                else
                    burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    send_operands(random_dividend(), random_divisor());
                    sent++;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: ;
                    3:       idle_cycles($urandom_range(DW, DW + 8));
                    4:       drain_results();
                    default: idle_cycles($urandom_range(1, 6));
                endcase
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operands = '0;
        error_count = 0;
        cycle_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_extreme_operands();
        test_zero_divisor();
        test_most_negative();
        test_random_stream();

        // catch stray beats after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
